[src/humidity_temperature_compensation_macros.svh]
// Assertion macros for the humidity and temperature compensation block.
`ifndef HUMIDITY_TEMPERATURE_COMPENSATION_MACROS_SVH
`define HUMIDITY_TEMPERATURE_COMPENSATION_MACROS_SVH
`ifndef SYNTH
// Checked property, ignored while reset is high
`define HTC_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("htc check failed");
// Checked property, also during reset
`define HTC_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("htc check failed");
`else
`define HTC_CHECK(lbl, clk, rst, prop)
`define HTC_CHECK_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/htc_pkg.sv]
// Shared types, constants and helpers of the compensation block.
`default_nettype none
package htc_pkg;
  localparam int FQ_DEPTH = 4;
  localparam int RQ_DEPTH = 32;
  localparam int PIPE_STAGES = 18;

  localparam logic [2:0] REG_T1 = 3'd0;
  localparam logic [2:0] REG_T2 = 3'd1;
  localparam logic [2:0] REG_T3 = 3'd2;
  localparam logic [2:0] REG_H13 = 3'd3;
  localparam logic [2:0] REG_H2 = 3'd4;
  localparam logic [2:0] REG_H4 = 3'd5;
  localparam logic [2:0] REG_H5 = 3'd6;
  localparam logic [2:0] REG_H6 = 3'd7;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } item_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        h13;
    logic signed [15:0] h2;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } trim_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic [16:0]        humidity_q10;
  } result_t;

  // Signed divide by 2**k, truncating toward zero
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v, input int k);
    logic [31:0]        mask;
    logic signed [31:0] sum;
    mask = (32'd1 << k) - 32'd1;
    sum = v + (v[31] ? $signed(mask) : 32'sd0);
    return sum >>> k;
  endfunction
endpackage
`default_nettype wire

[src/humidity_temperature_compensation.sv]
// Top level: config registers, front queue, datapath, result queue.
`default_nettype none
`include "humidity_temperature_compensation_macros.svh"
// Integer trim compensation of raw temperature and humidity samples. One
// sample pair can be pushed every clock cycle while full is low. Pairs in
// the 4-entry input queue are issued into the first of the 18 datapath
// stages, and each result is written to the result queue from the last
// stage. Issue is held off while 32 results, the depth of the result queue,
// are in flight or waiting; the input queue then fills and raises full.
// Trim registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no sample is in flight.
module humidity_temperature_compensation import htc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [15:0] raw_humidity,
  output logic             empty,
  input  wire logic        pop,
  output logic signed [31:0] fine_temperature,
  output logic signed [31:0] temperature_centi,
  output logic [16:0]      humidity_q10,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int CW = $clog2(RQ_DEPTH) + 1;

  trim_t     trim;
  item_t     push_item;
  item_t     head;
  logic      has_item;
  logic      issue;
  logic      res_valid;
  result_t   res;
  result_t   out_head;
  logic [CW-1:0] credit;
  logic      popped;

  // trim registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trim <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_T1:  trim.t1 <= cfg_data;
        REG_T2:  trim.t2 <= $signed(cfg_data);
        REG_T3:  trim.t3 <= $signed(cfg_data);
        REG_H13: trim.h13 <= cfg_data;
        REG_H2:  trim.h2 <= $signed(cfg_data);
        REG_H4:  trim.h4 <= $signed(cfg_data[11:0]);
        REG_H5:  trim.h5 <= $signed(cfg_data[11:0]);
        REG_H6:  trim.h6 <= $signed(cfg_data[7:0]);
        default: trim <= trim;
      endcase
    end
  end

  assign push_item.raw_temperature = raw_temperature;
  assign push_item.raw_humidity = raw_humidity;

  htc_front u_front (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(full),
    .has_item(has_item), .take(issue), .head(head)
  );

  // issue only with a result slot reserved
  assign issue = has_item && (credit < CW'(RQ_DEPTH));
  assign popped = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CW'(issue) - CW'(popped);
    end
  end

  htc_back u_back (
    .clk(clk), .rst(rst), .in_valid(issue), .in_item(head), .trim(trim),
    .out_valid(res_valid), .out_res(res)
  );

  htc_res_queue u_res (
    .clk(clk), .rst(rst), .wr(res_valid), .wr_res(res), .pop(pop),
    .empty(empty), .head(out_head)
  );

  assign fine_temperature = out_head.fine_temperature;
  assign temperature_centi = out_head.temperature_centi;
  assign humidity_q10 = out_head.humidity_q10;

  `HTC_CHECK(credit_bound, clk, rst, credit <= CW'(RQ_DEPTH))
  `HTC_CHECK(credit_drop, clk, rst, popped && !issue |=> credit == $past(credit) - 1'b1)
  `HTC_CHECK_ALWAYS(reset_clears_credit, clk, rst |=> credit == '0)
endmodule
`default_nettype wire

[src/htc_front.sv]
// Input queue: takes sample pairs and hands them to the datapath.
`default_nettype none
module htc_front import htc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  output logic       has_item,
  input  wire logic  take,
  output item_t      head
);
  localparam int AW = $clog2(FQ_DEPTH);

  item_t            mem [FQ_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             wr;
  logic             rd;

  assign full = (count == (AW+1)'(FQ_DEPTH));
  assign has_item = (count != '0);
  assign wr = push && !full;
  assign rd = take && has_item;
  assign head = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule
`default_nettype wire

[src/htc_back.sv]
// Compensation datapath: 18 stages.
`default_nettype none
module htc_back import htc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  input  wire trim_t trim,
  output logic       out_valid,
  output result_t    out_res
);
  logic [PIPE_STAGES-1:0] v;
  logic signed [31:0] t2s, t3s, h2s, h4s, h5s, h6s, h1s, h3s;
  logic signed [31:0] t_in;

  logic signed [31:0] xa1, ya1, xm2, yy2, x3, yq3, x4, ym4, fine5;
  logic signed [31:0] fine6, cp6, a6, fine7, centi7, dm7, m6_7, m3_7;
  logic signed [31:0] e8, b8, c8, p9, d10, q11, b12;
  logic signed [31:0] e9, e10, e11, e12;
  logic signed [31:0] c13, c14, cq14, c15, d15, c16, dd16, c17, m17;
  logic signed [31:0] ee18;
  logic [15:0] h1, h2, h3, h4, h5, h6, h7;
  logic [16:0] hum18;
  logic signed [31:0] fine_sr [11];
  logic signed [31:0] centi_sr [11];

  assign t2s = 32'(trim.t2);
  assign t3s = 32'(trim.t3);
  assign h2s = 32'(trim.h2);
  assign h4s = 32'(trim.h4);
  assign h5s = 32'(trim.h5);
  assign h6s = 32'(trim.h6);
  assign h1s = $signed({24'b0, trim.h13[7:0]});
  assign h3s = $signed({24'b0, trim.h13[15:8]});
  assign t_in = $signed({12'b0, in_item.raw_temperature});

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[PIPE_STAGES-2:0], in_valid};
    end
  end

  // temperature stages
  always_ff @(posedge clk) begin
    xa1 <= (t_in >>> 3) - $signed({15'b0, trim.t1, 1'b0});
    ya1 <= (t_in >>> 4) - $signed({16'b0, trim.t1});
    h1 <= in_item.raw_humidity;
    xm2 <= xa1 * t2s;
    yy2 <= ya1 * ya1;
    h2 <= h1;
    x3 <= sdiv_pow2(xm2, 11);
    yq3 <= sdiv_pow2(yy2, 12);
    h3 <= h2;
    x4 <= x3;
    ym4 <= yq3 * t3s;
    h4 <= h3;
    fine5 <= x4 + sdiv_pow2(ym4, 14);
    h5 <= h4;
    fine6 <= fine5;
    cp6 <= fine5 * 32'sd5 + 32'sd128;
    a6 <= fine5 - 32'sd76800;
    h6 <= h5;
    fine7 <= fine6;
    centi7 <= sdiv_pow2(cp6, 8);
    dm7 <= h5s * a6;
    m6_7 <= a6 * h6s;
    m3_7 <= a6 * h3s;
    h7 <= h6;
  end

  // humidity stages
  always_ff @(posedge clk) begin
    e8 <= sdiv_pow2($signed({2'b0, h7, 14'b0}) - (h4s <<< 20) - dm7 + 32'sd16384, 15);
    b8 <= sdiv_pow2(m6_7, 10);
    c8 <= sdiv_pow2(m3_7, 11) + 32'sd32768;
    e9 <= e8;
    p9 <= b8 * c8;
    e10 <= e9;
    d10 <= sdiv_pow2(p9, 10) + 32'sd2097152;
    e11 <= e10;
    q11 <= d10 * h2s;
    e12 <= e11;
    b12 <= sdiv_pow2(q11 + 32'sd8192, 14);
    c13 <= e12 * b12;
    c14 <= c13;
    cq14 <= sdiv_pow2(c13, 15);
    c15 <= c14;
    d15 <= cq14 * cq14;
    c16 <= c15;
    dd16 <= sdiv_pow2(d15, 7);
    c17 <= c16;
    m17 <= dd16 * h1s;
    hum18 <= ee18[28:12];
  end

  // clamp to 0..100 percent in Q.22 before scaling
  always_comb begin
    ee18 = c17 - sdiv_pow2(m17, 4);
    if (ee18 < 0) begin
      ee18 = '0;
    end else if (ee18 > 32'sd419430400) begin
      ee18 = 32'sd419430400;
    end
  end

  // carry temperature results alongside
  always_ff @(posedge clk) begin
    fine_sr[0] <= fine7;
    centi_sr[0] <= centi7;
    for (int i = 1; i < 11; i++) begin
      fine_sr[i] <= fine_sr[i-1];
      centi_sr[i] <= centi_sr[i-1];
    end
  end

  assign out_valid = v[PIPE_STAGES-1];
  assign out_res.fine_temperature = fine_sr[10];
  assign out_res.temperature_centi = centi_sr[10];
  assign out_res.humidity_q10 = hum18;
endmodule
`default_nettype wire

[src/htc_res_queue.sv]
// Result queue between the datapath and the consumer.
`default_nettype none
`include "humidity_temperature_compensation_macros.svh"
module htc_res_queue import htc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr,
  input  wire result_t wr_res,
  input  wire logic    pop,
  output logic         empty,
  output result_t      head
);
  localparam int AW = $clog2(RQ_DEPTH);

  result_t       mem [RQ_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          rd;

  assign empty = (count == '0);
  assign rd = pop && !empty;
  assign head = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_res;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  // credit scheme must keep a slot free for every beat in flight
  `HTC_CHECK(no_overflow, clk, rst, !(wr && count == (AW+1)'(RQ_DEPTH)))
endmodule
`default_nettype wire
